@@ design/murmur64a_hash_unit_assert.svh @@
// ----------------------------------------------------------------------------
// murmur64a_hash_unit assertion macros
// Clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef MURMUR64A_HASH_UNIT_ASSERT_SVH
`define MURMUR64A_HASH_UNIT_ASSERT_SVH

// Property must hold at every edge out of reset.
`define MH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define MH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/mh64_pkg.sv @@
// ----------------------------------------------------------------------------
// mh64_pkg
// Shared constants and types of the MurmurHash64A unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mh64_pkg;

  localparam logic [63:0] MIX_MUL   = 64'hc6a4a7935bd1e995;
  localparam int          MIX_SHIFT = 47;
  localparam logic [3:0]  BYTES_FULL = 4'd8;

  typedef enum logic [1:0] {
    OP_SKIP,
    OP_TAIL,
    OP_FULL
  } op_kind_t;

  typedef struct packed {
    logic [63:0] word;
    op_kind_t    kind;
    logic        first;
    logic        last;
    logic [31:0] len;
  } q_entry_t;

  typedef struct packed {
    logic        start;
    logic [63:0] operand;
  } mul_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] result;
  } mul_rsp_t;

endpackage

@@ design/mh64_front.sv @@
// ----------------------------------------------------------------------------
// mh64_front
// Input side: classifies each word, masks tail bytes, two-entry queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mh64_front import mh64_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] data_word,
  input  logic [3:0]  bytes_valid,
  input  logic        first_word,
  input  logic        last_word,
  input  logic [31:0] message_length,
  input  logic        pop,
  output logic        q_valid,
  output q_entry_t    q_entry
);

  q_entry_t   entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  q_entry_t   cls;

  always_comb begin
    cls.first = first_word;
    cls.last  = last_word;
    cls.len   = message_length;
    for (int i = 0; i < 8; i++) begin
      cls.word[8*i +: 8] = (4'(i) < bytes_valid) ? data_word[8*i +: 8] : 8'h00;
    end
    if (bytes_valid >= BYTES_FULL) begin
      cls.kind = OP_FULL;
      cls.word = data_word;
    end else if (bytes_valid == 4'd0) begin
      cls.kind = OP_SKIP;
    end else begin
      cls.kind = OP_TAIL;
    end
  end

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_entry  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        entries[wr_ptr] <= cls;
        wr_ptr          <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

@@ design/mh64_mul.sv @@
// ----------------------------------------------------------------------------
// mh64_mul
// Multi-cycle 64-bit multiply by the mix constant, modulo 2^64.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mh64_mul import mh64_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  logic [63:0] x;
  logic [63:0] prod;
  logic [63:0] acc;
  logic [63:0] result;
  logic [1:0]  step;
  logic        busy;
  logic        done;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] pp;

  // Only three partial products reach the low 64 bits.
  always_comb begin
    case (step)
      2'd0: begin
        mul_a = x[31:0];
        mul_b = MIX_MUL[31:0];
      end
      2'd1: begin
        mul_a = x[31:0];
        mul_b = MIX_MUL[63:32];
      end
      default: begin
        mul_a = x[63:32];
        mul_b = MIX_MUL[31:0];
      end
    endcase
  end

  assign pp = 64'(mul_a) * 64'(mul_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 2'd0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        x    <= req.operand;
        step <= 2'd0;
        busy <= 1'b1;
      end else if (busy) begin
        case (step)
          2'd0: begin
            prod <= pp;
            step <= 2'd1;
          end
          2'd1: begin
            acc  <= prod;
            prod <= pp;
            step <= 2'd2;
          end
          2'd2: begin
            acc  <= acc + {prod[31:0], 32'h0};
            prod <= pp;
            step <= 2'd3;
          end
          default: begin
            result <= acc + {prod[31:0], 32'h0};
            done   <= 1'b1;
            busy   <= 1'b0;
            step   <= 2'd0;
          end
        endcase
      end
    end
  end

  assign rsp.busy   = busy;
  assign rsp.done   = done;
  assign rsp.result = result;

endmodule

@@ design/mh64_back.sv @@
// ----------------------------------------------------------------------------
// mh64_back
// Accumulator sequencer: seeds, absorbs, finalizes and holds the digest.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "murmur64a_hash_unit_assert.svh"

module mh64_back import mh64_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  q_entry_t    q_entry,
  output logic        pop,
  input  logic        hash_seed_valid,
  input  logic [63:0] hash_seed,
  output mul_req_t    mul_req,
  input  mul_rsp_t    mul_rsp,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] digest
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LEN,
    S_K1,
    S_K2,
    S_TAIL,
    S_ACC,
    S_FIN,
    S_OUT
  } state_t;

  state_t      state;
  q_entry_t    cur;
  logic [63:0] seed;
  logic [63:0] h;
  logic [63:0] k;
  logic        issued;
  logic [63:0] res;

  function automatic state_t absorb_state(op_kind_t kind);
    case (kind)
      OP_FULL: absorb_state = S_K1;
      OP_TAIL: absorb_state = S_TAIL;
      default: absorb_state = S_FIN;
    endcase
  endfunction

  assign res = mul_rsp.result;
  assign pop = (state == S_IDLE) && q_valid;

  always_comb begin
    case (state)
      S_LEN:   mul_req.operand = {32'h0, cur.len};
      S_K1:    mul_req.operand = cur.word;
      S_K2:    mul_req.operand = k;
      S_ACC:   mul_req.operand = h;
      S_FIN:   mul_req.operand = h ^ (h >> MIX_SHIFT);
      default: mul_req.operand = h;
    endcase
    mul_req.start = !issued &&
                    ((state inside {S_LEN, S_K1, S_K2, S_ACC}) ||
                     (state == S_FIN && cur.last));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      issued    <= 1'b0;
      seed      <= 64'h0;
      h         <= 64'h0;
      out_valid <= 1'b0;
    end else begin
      if (hash_seed_valid) begin
        seed <= hash_seed;
      end
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      if (mul_req.start) begin
        issued <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur   <= q_entry;
            state <= q_entry.first ? S_LEN : absorb_state(q_entry.kind);
          end
        end
        S_LEN: begin
          if (mul_rsp.done) begin
            issued <= 1'b0;
            h      <= seed ^ res;
            state  <= absorb_state(cur.kind);
          end
        end
        S_K1: begin
          if (mul_rsp.done) begin
            issued <= 1'b0;
            k      <= res ^ (res >> MIX_SHIFT);
            state  <= S_K2;
          end
        end
        S_K2: begin
          if (mul_rsp.done) begin
            issued <= 1'b0;
            h      <= h ^ res;
            state  <= S_ACC;
          end
        end
        S_TAIL: begin
          h     <= h ^ cur.word;
          state <= S_ACC;
        end
        S_ACC: begin
          if (mul_rsp.done) begin
            issued <= 1'b0;
            h      <= res;
            state  <= S_FIN;
          end
        end
        S_FIN: begin
          if (!cur.last) begin
            state <= S_IDLE;
          end else if (mul_rsp.done) begin
            issued <= 1'b0;
            k      <= res ^ (res >> MIX_SHIFT);
            state  <= S_OUT;
          end
        end
        S_OUT: begin
          // hold until the output register is free or being emptied
          if (!out_valid || !out_stall) begin
            digest    <= k;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `MH_ASSERT(a_start_idle, mul_req.start |-> !mul_rsp.busy, "multiply started while busy")
  `MH_ASSERT(a_done_busy, mul_rsp.done |-> $past(mul_rsp.busy), "done without busy")
  `MH_ASSERT(a_pop_valid, pop |-> q_valid, "pop from empty queue")
  `MH_ASSERT(a_out_last, (state == S_OUT) |-> cur.last, "digest for non-last word")
  `MH_ASSERT_NEXT(a_issue_hold, issued && !mul_rsp.done, issued, "issue flag dropped")

endmodule

@@ design/murmur64a_hash_unit.sv @@
// ----------------------------------------------------------------------------
// murmur64a_hash_unit
// MurmurHash64A over a message of little-endian 64-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one word: data_word,
//   bytes_valid, first_word, last_word, message_length. A word is taken when
//   in_valid is high and in_stall low. A two-entry queue sits in front of
//   the hash sequencer, so words are taken while an earlier one is at work.
//   Output channel (out_valid / out_stall) carries one digest per last word.
//   The digest register holds while out_stall is high; the sequencer waits
//   only when a second digest is ready before the first is taken.
//   hash_seed is written over its own valid/ready port (ready is always
//   high); write it only while no message is in flight.
//   Multiplier: every 64-bit multiply by the mix constant runs on one shared
//   32x32 multiplier in three partial products. A word takes 3 multiplies
//   if full, 1 if a tail, +1 on a first word, +1 on a last word; a tail word
//   adds an XOR step, and a word leaves through the output load on a last
//   word, through the finalize pass otherwise.
//   Reset (rst, synchronous): clears the queue, the seed and the accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module murmur64a_hash_unit import mh64_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] data_word,
  input  logic [3:0]  bytes_valid,
  input  logic        first_word,
  input  logic        last_word,
  input  logic [31:0] message_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] digest,
  input  logic        hash_seed_valid,
  output logic        hash_seed_ready,
  input  logic [63:0] hash_seed
);

  logic     q_valid;
  q_entry_t q_entry;
  logic     pop;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  assign hash_seed_ready = 1'b1;

  mh64_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_word      (data_word),
    .bytes_valid    (bytes_valid),
    .first_word     (first_word),
    .last_word      (last_word),
    .message_length (message_length),
    .pop            (pop),
    .q_valid        (q_valid),
    .q_entry        (q_entry)
  );

  mh64_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  mh64_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_entry         (q_entry),
    .pop             (pop),
    .hash_seed_valid (hash_seed_valid),
    .hash_seed       (hash_seed),
    .mul_req         (mul_req),
    .mul_rsp         (mul_rsp),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .digest          (digest)
  );

endmodule
